@@ src/mstt_pkg.sv @@
// ----------------------------------------------------------------------------
// mstt_pkg
// shared types, codes and helpers of the multi-slot timer table
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int IV_W      = 24;
    localparam int ID_W      = 31;
    localparam int TIME_W    = 48;
    localparam int CNT_W     = 7;

    localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_ONESHOT    = 3'd0,
        CMD_PERIODIC   = 3'd1,
        CMD_CANCEL     = 3'd2,
        CMD_CANCEL_ALL = 3'd3,
        CMD_TICK       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_IDLE   = 2'd2,
        KIND_CANCEL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // one slot of the table memory
    typedef struct packed {
        logic              periodic;
        logic [ID_W-1:0]   id;
        logic [IV_W-1:0]   period;
        logic [TIME_W-1:0] deadline;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic exec;
        logic rd_en;
        logic chk;
        logic fin;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic cancel_hit;
    } t_sts;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                  input logic [IV_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W+1-IV_W){1'b0}}, d};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

@@ src/mstt_ram.sv @@
// ----------------------------------------------------------------------------
// mstt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mstt_ram #(
    parameter int W = 8,
    parameter int D = 64,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mstt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mstt_ctrl
// command sequencer: accepts items and walks the slot scan
// ----------------------------------------------------------------------------
module mstt_ctrl #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEF,
    parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_command,
    input  mstt_pkg::t_sts  i_sts,
    output mstt_pkg::t_ctl  o_ctl,
    output logic [IW-1:0]   o_rd_addr,
    output logic [IW-1:0]   o_chk_idx,
    output logic            o_busy
);

    mstt_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_ra, n_ra;
    logic [IW-1:0]    r_ci, n_ci;
    logic             r_cv, n_cv;
    logic             cmd_ok, cmd_scan;

    assign cmd_ok   = (i_command == mstt_pkg::CMD_ONESHOT)
                   || (i_command == mstt_pkg::CMD_PERIODIC)
                   || (i_command == mstt_pkg::CMD_CANCEL)
                   || (i_command == mstt_pkg::CMD_CANCEL_ALL)
                   || (i_command == mstt_pkg::CMD_TICK);
    assign cmd_scan = (i_command == mstt_pkg::CMD_CANCEL)
                   || (i_command == mstt_pkg::CMD_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mstt_pkg::ST_IDLE;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cv    <= n_cv;
        end
        r_ra <= n_ra;
        r_ci <= n_ci;
    end

    always_comb begin
        n_state = r_state;
        n_ra    = r_ra;
        n_ci    = r_ci;
        n_cv    = 1'b0;
        o_ctl   = '0;
        case (r_state)
            mstt_pkg::ST_IDLE: begin
                n_ra = '0;
                if (i_start && cmd_ok) begin
                    o_ctl.cap = 1'b1;
                    n_state   = cmd_scan ? mstt_pkg::ST_SCAN : mstt_pkg::ST_EXEC;
                end
            end
            mstt_pkg::ST_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = mstt_pkg::ST_IDLE;
            end
            mstt_pkg::ST_SCAN: begin
                o_ctl.rd_en = 1'b1;
                o_ctl.chk   = r_cv;
                n_cv        = 1'b1;
                n_ci        = r_ra;
                if (r_cv && i_sts.cancel_hit) begin
                    n_cv    = 1'b0;
                    n_state = mstt_pkg::ST_FIN;
                end else if (r_ra == IW'(SLOTS - 1)) begin
                    n_state = mstt_pkg::ST_DRAIN;
                end else begin
                    n_ra = r_ra + 1'b1;
                end
            end
            mstt_pkg::ST_DRAIN: begin
                o_ctl.chk = r_cv;
                n_state   = mstt_pkg::ST_FIN;
            end
            mstt_pkg::ST_FIN: begin
                o_ctl.fin = 1'b1;
                n_state   = mstt_pkg::ST_IDLE;
            end
            default: begin
                n_state = mstt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr = r_ra;
    assign o_chk_idx = r_ci;
    assign o_busy    = (r_state != mstt_pkg::ST_IDLE);

endmodule

@@ src/mstt_dp.sv @@
// ----------------------------------------------------------------------------
// mstt_dp
// slot table datapath: active bits, slot memory, expiry check, result regs
// ----------------------------------------------------------------------------
module mstt_dp #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEF,
    parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mstt_pkg::t_ctl              i_ctl,
    input  logic [IW-1:0]               i_rd_addr,
    input  logic [IW-1:0]               i_chk_idx,
    input  logic [2:0]                  i_command,
    input  logic [mstt_pkg::IV_W-1:0]   i_interval,
    input  logic [mstt_pkg::ID_W-1:0]   i_target_id,
    input  logic [mstt_pkg::TIME_W-1:0] i_now_time,
    output mstt_pkg::t_sts              o_sts,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic [mstt_pkg::ID_W-1:0]   o_result_id,
    output logic [mstt_pkg::CNT_W-1:0]  o_fired_count,
    output logic                        o_last
);

    localparam int SW = $bits(mstt_pkg::t_slot);

    // captured item
    logic [2:0]                  r_cmd;
    logic [mstt_pkg::IV_W-1:0]   r_iv;
    logic [mstt_pkg::ID_W-1:0]   r_target;
    logic [mstt_pkg::TIME_W-1:0] r_now;

    // control state
    logic [SLOTS-1:0]            r_active, n_active;
    logic [mstt_pkg::ID_W-1:0]   r_next_id, n_next_id;
    logic                        r_valid, n_valid;
    logic                        r_pv, n_pv;
    logic [mstt_pkg::CNT_W-1:0]  r_fcnt, n_fcnt;

    // payload
    logic [mstt_pkg::ID_W-1:0]   r_pid, n_pid;
    logic [mstt_pkg::CNT_W-1:0]  r_pcnt, n_pcnt;
    logic [1:0]                  r_kind, n_kind;
    logic [mstt_pkg::ID_W-1:0]   r_id, n_id;
    logic [mstt_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_last, n_last;

    logic                        we;
    logic [IW-1:0]               waddr;
    mstt_pkg::t_slot             wslot, rslot;
    logic [SW-1:0]               rdata;

    logic                        found;
    logic [IW-1:0]               fidx;
    logic                        is_tick, is_cancel, is_create;
    logic                        act, fire, chit;
    logic [mstt_pkg::TIME_W-1:0] d_old, d_now, d_new;

    mstt_ram #(.W(SW), .D(SLOTS), .AW(IW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wslot),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (rdata)
    );

    assign rslot = mstt_pkg::t_slot'(rdata);

    assign is_tick   = (r_cmd == mstt_pkg::CMD_TICK);
    assign is_cancel = (r_cmd == mstt_pkg::CMD_CANCEL);
    assign is_create = (r_cmd == mstt_pkg::CMD_ONESHOT) || (r_cmd == mstt_pkg::CMD_PERIODIC);

    // lowest free slot
    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                found = 1'b1;
                fidx  = IW'(i);
            end
        end
    end

    assign act   = r_active[i_chk_idx];
    assign fire  = is_tick && act && !(r_now < rslot.deadline);
    assign chit  = is_cancel && act && (r_target != '0) && (rslot.id == r_target);
    assign d_old = mstt_pkg::sat_add(rslot.deadline, rslot.period);
    assign d_now = mstt_pkg::sat_add(r_now, rslot.period);
    assign d_new = (d_old < r_now) ? d_now : d_old;

    assign o_sts.cancel_hit = i_ctl.chk && chit;

    always_comb begin
        n_active  = r_active;
        n_next_id = r_next_id;
        n_valid   = 1'b0;
        n_pv      = r_pv;
        n_fcnt    = r_fcnt;
        n_pid     = r_pid;
        n_pcnt    = r_pcnt;
        n_kind    = r_kind;
        n_id      = r_id;
        n_cnt     = r_cnt;
        n_last    = r_last;
        we        = 1'b0;
        waddr     = i_chk_idx;
        wslot     = rslot;

        if (i_ctl.cap) begin
            n_pv   = 1'b0;
            n_fcnt = '0;
        end

        if (i_ctl.exec) begin
            n_valid = 1'b1;
            n_cnt   = '0;
            n_last  = 1'b1;
            n_id    = '0;
            if (is_create) begin
                n_kind = mstt_pkg::KIND_CREATE;
                if ((r_iv != '0) && found) begin
                    n_active[fidx] = 1'b1;
                    n_id           = r_next_id;
                    n_next_id      = (r_next_id == mstt_pkg::ID_MAX) ? mstt_pkg::ID_W'(1)
                                                                     : r_next_id + 1'b1;
                    we             = 1'b1;
                    waddr          = fidx;
                    wslot.periodic = (r_cmd == mstt_pkg::CMD_PERIODIC);
                    wslot.id       = r_next_id;
                    wslot.period   = r_iv;
                    wslot.deadline = mstt_pkg::sat_add(r_now, r_iv);
                end
            end else begin
                n_kind   = mstt_pkg::KIND_CANCEL;
                n_active = '0;
            end
        end

        if (i_ctl.chk) begin
            if (fire) begin
                // hold each event until the next one shows whether it is final
                if (r_pv) begin
                    n_valid = 1'b1;
                    n_kind  = mstt_pkg::KIND_FIRED;
                    n_id    = r_pid;
                    n_cnt   = r_pcnt;
                    n_last  = 1'b0;
                end
                n_pv   = 1'b1;
                n_pid  = rslot.id;
                n_pcnt = r_fcnt + 1'b1;
                n_fcnt = r_fcnt + 1'b1;
                if (rslot.periodic) begin
                    we             = 1'b1;
                    wslot.deadline = d_new;
                end else begin
                    n_active[i_chk_idx] = 1'b0;
                end
            end
            if (chit) begin
                n_active[i_chk_idx] = 1'b0;
            end
        end

        if (i_ctl.fin) begin
            n_valid = 1'b1;
            n_last  = 1'b1;
            if (is_tick && r_pv) begin
                n_kind = mstt_pkg::KIND_FIRED;
                n_id   = r_pid;
                n_cnt  = r_pcnt;
            end else begin
                n_kind = is_tick ? mstt_pkg::KIND_IDLE : mstt_pkg::KIND_CANCEL;
                n_id   = '0;
                n_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_next_id <= mstt_pkg::ID_W'(1);
            r_valid   <= 1'b0;
            r_pv      <= 1'b0;
            r_fcnt    <= '0;
        end else begin
            r_active  <= n_active;
            r_next_id <= n_next_id;
            r_valid   <= n_valid;
            r_pv      <= n_pv;
            r_fcnt    <= n_fcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_cmd    <= i_command;
            r_iv     <= i_interval;
            r_target <= i_target_id;
            r_now    <= i_now_time;
        end
        r_pid  <= n_pid;
        r_pcnt <= n_pcnt;
        r_kind <= n_kind;
        r_id   <= n_id;
        r_cnt  <= n_cnt;
        r_last <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_result_id   = r_id;
    assign o_fired_count = r_cnt;
    assign o_last        = r_last;

endmodule

@@ src/multi_slot_timer_table_unit.sv @@
// ----------------------------------------------------------------------------
// multi_slot_timer_table_unit
// table of one-shot and periodic timer slots driven by create, cancel and tick
// ----------------------------------------------------------------------------
// usage:
//   an item is taken at a clock edge with start high and busy low; command
//   selects create one-shot, create periodic, cancel, cancel all or tick.
//   unknown command codes are dropped and give no result.
//   results come out one per cycle on o_valid, with o_last on the final
//   result of the item; the receiver cannot hold them off.
// timing:
//   create and cancel all: one result, registered from the exec state.
//   cancel and tick walk the slot memory one slot a cycle through its single
//   read port; cancel stops early at the first match.
//   fired events leave as they are found, each delayed until the next one or
//   the end of the walk, so that the last one can be marked.
//   busy drops in the cycle the final result is driven; a new item can be
//   taken in that cycle.
// reset:
//   synchronous active-low; frees every slot and sets the next id to one.
//   slot contents are not cleared, only their active bits.
// ----------------------------------------------------------------------------
module multi_slot_timer_table_unit #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_command,
    input  logic [mstt_pkg::IV_W-1:0]   i_interval,
    input  logic [mstt_pkg::ID_W-1:0]   i_target_id,
    input  logic [mstt_pkg::TIME_W-1:0] i_now_time,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic [mstt_pkg::ID_W-1:0]   o_result_id,
    output logic [mstt_pkg::CNT_W-1:0]  o_fired_count,
    output logic                        o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mstt_pkg::t_ctl ctl;
    mstt_pkg::t_sts sts;
    logic [IW-1:0]  rd_addr;
    logic [IW-1:0]  chk_idx;

    // sequencer: accept, scan walk and result timing
    mstt_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .o_rd_addr (rd_addr),
        .o_chk_idx (chk_idx),
        .o_busy    (busy)
    );

    // slot storage, expiry and reschedule arithmetic, result registers
    mstt_dp #(.SLOTS(SLOTS), .IW(IW)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_rd_addr     (rd_addr),
        .i_chk_idx     (chk_idx),
        .i_command     (i_command),
        .i_interval    (i_interval),
        .i_target_id   (i_target_id),
        .i_now_time    (i_now_time),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_result_id   (o_result_id),
        .o_fired_count (o_fired_count),
        .o_last        (o_last)
    );

endmodule

@@ src/mstt_checker.sv @@
// ----------------------------------------------------------------------------
// mstt_checker
// port-level checks of the timer table, bound to the top level
// ----------------------------------------------------------------------------
module mstt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [2:0]                  i_command,
    input logic                        o_valid,
    input logic [1:0]                  o_kind,
    input logic [mstt_pkg::ID_W-1:0]   o_result_id,
    input logic [mstt_pkg::CNT_W-1:0]  o_fired_count,
    input logic                        o_last
);

    // a known command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command <= mstt_pkg::CMD_TICK)) |=> busy)
        else $error("accepted item did not raise busy");

    // single-result kinds always close their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind != mstt_pkg::KIND_FIRED)) |-> (o_last && o_fired_count == '0))
        else $error("create, idle or cancel result not final");

    // an empty tick reports no id
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == mstt_pkg::KIND_IDLE)) |-> (o_result_id == '0))
        else $error("empty tick carries an id");

    // fired events count from one and carry a real id
    a_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == mstt_pkg::KIND_FIRED))
            |-> (o_fired_count != '0 && o_result_id != '0))
        else $error("fired event with zero count or id");

    // no result follows directly after the final one
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result right after final result");

endmodule

bind multi_slot_timer_table_unit mstt_checker u_mstt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .o_kind        (o_kind),
    .o_result_id   (o_result_id),
    .o_fired_count (o_fired_count),
    .o_last        (o_last)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the multi-slot timer table: directed rows, then
// random command streams, every result compared against a software table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int N_SLOTS   = 64;
    localparam int N_RANDOM  = 280;
    localparam longint LIMIT = 2_000_000;

    // result item as seen on the ports
    typedef struct packed {
        logic [1:0]                  kind;
        logic [mstt_pkg::ID_W-1:0]   id;
        logic [mstt_pkg::CNT_W-1:0]  cnt;
        logic                        last;
    } t_event;

    // one directed row; chk_id set means the id is typed in
    typedef struct {
        logic [2:0]                  cmd;
        logic [mstt_pkg::IV_W-1:0]   iv;
        logic [mstt_pkg::ID_W-1:0]   tgt;
        logic [mstt_pkg::TIME_W-1:0] now;
        bit                          chk_id;
        logic [mstt_pkg::ID_W-1:0]   want_id;
    } t_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [2:0]                  i_command;
    logic [mstt_pkg::IV_W-1:0]   i_interval;
    logic [mstt_pkg::ID_W-1:0]   i_target_id;
    logic [mstt_pkg::TIME_W-1:0] i_now_time;
    logic                        o_valid;
    logic [1:0]                  o_kind;
    logic [mstt_pkg::ID_W-1:0]   o_result_id;
    logic [mstt_pkg::CNT_W-1:0]  o_fired_count;
    logic                        o_last;

    multi_slot_timer_table_unit i_dut (.*);

    // software copy of the timer table
    bit                          tt_active   [N_SLOTS];
    bit                          tt_periodic [N_SLOTS];
    logic [mstt_pkg::ID_W-1:0]   tt_id       [N_SLOTS];
    logic [mstt_pkg::IV_W-1:0]   tt_period   [N_SLOTS];
    logic [mstt_pkg::TIME_W-1:0] tt_deadline [N_SLOTS];
    logic [mstt_pkg::ID_W-1:0]   tt_next_id;

    t_event     pending_events[$];
    int         n_errors;
    int         n_results;
    int         n_fired;
    int         n_items;
    longint     n_cycles;
    logic [mstt_pkg::TIME_W-1:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // saturating deadline sum, written fresh for the bench
    function automatic logic [mstt_pkg::TIME_W-1:0] deadline_of(
            logic [mstt_pkg::TIME_W-1:0] t, logic [mstt_pkg::IV_W-1:0] d);
        logic [mstt_pkg::TIME_W:0] s;
        s = t + d;
        if (s > {1'b0, mstt_pkg::TIME_MAX})
            return mstt_pkg::TIME_MAX;
        return s[mstt_pkg::TIME_W-1:0];
    endfunction

    function automatic void push_event(mstt_pkg::t_kind k, logic [mstt_pkg::ID_W-1:0] id,
                                       int cnt, bit last);
        t_event e;
        e.kind = k;
        e.id   = id;
        e.cnt  = cnt[mstt_pkg::CNT_W-1:0];
        e.last = last;
        pending_events.push_back(e);
    endfunction

    // apply one command to the software table, queue what it should emit
    function automatic void predict_timer_cmd(logic [2:0] cmd,
                                              logic [mstt_pkg::IV_W-1:0] iv,
                                              logic [mstt_pkg::ID_W-1:0] tgt,
                                              logic [mstt_pkg::TIME_W-1:0] now);
        logic [mstt_pkg::ID_W-1:0]   id;
        logic [mstt_pkg::TIME_W-1:0] d;
        int                          n;
        n  = 0;
        id = '0;
        case (cmd)
            mstt_pkg::CMD_ONESHOT, mstt_pkg::CMD_PERIODIC: begin
                if (iv != 0) begin
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (!tt_active[i]) begin
                            id = tt_next_id;
                            tt_next_id = (tt_next_id == mstt_pkg::ID_MAX)
                                         ? mstt_pkg::ID_W'(1) : tt_next_id + 1'b1;
                            tt_active[i]   = 1'b1;
                            tt_periodic[i] = (cmd == mstt_pkg::CMD_PERIODIC);
                            tt_id[i]       = id;
                            tt_period[i]   = iv;
                            tt_deadline[i] = deadline_of(now, iv);
                            break;
                        end
                    end
                end
                push_event(mstt_pkg::KIND_CREATE, id, 0, 1'b1);
            end
            mstt_pkg::CMD_CANCEL: begin
                if (tgt != 0) begin
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (tt_active[i] && tt_id[i] == tgt) begin
                            tt_active[i] = 1'b0;
                            break;
                        end
                    end
                end
                push_event(mstt_pkg::KIND_CANCEL, '0, 0, 1'b1);
            end
            mstt_pkg::CMD_CANCEL_ALL: begin
                foreach (tt_active[i]) tt_active[i] = 1'b0;
                push_event(mstt_pkg::KIND_CANCEL, '0, 0, 1'b1);
            end
            mstt_pkg::CMD_TICK: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (!tt_active[i] || now < tt_deadline[i])
                        continue;
                    n++;
                    push_event(mstt_pkg::KIND_FIRED, tt_id[i], n, 1'b0);
                    if (tt_periodic[i]) begin
                        d = deadline_of(tt_deadline[i], tt_period[i]);
                        if (d < now)
                            d = deadline_of(now, tt_period[i]);
                        tt_deadline[i] = d;
                    end else begin
                        tt_active[i] = 1'b0;
                    end
                end
                // the final fired event carries the last flag
                if (n == 0)
                    push_event(mstt_pkg::KIND_IDLE, '0, 0, 1'b1);
                else
                    pending_events[$].last = 1'b1;
            end
            default: ;  // unknown codes give no result
        endcase
    endfunction

    // result checker: strobe sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_event e;
            n_results++;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result kind %0d id %0d", $time, o_kind,
                         o_result_id);
                n_errors++;
            end else begin
                e = pending_events.pop_front();
                if (o_kind == mstt_pkg::KIND_FIRED)
                    n_fired++;
                if (o_kind !== e.kind || o_result_id !== e.id ||
                    o_fired_count !== e.cnt || o_last !== e.last) begin
                    $display("%0t: mismatch exp k%0d id%0d c%0d l%0d got k%0d id%0d c%0d l%0d",
                             $time, e.kind, e.id, e.cnt, e.last, o_kind,
                             o_result_id, o_fired_count, o_last);
                    n_errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("timeout with %0d results outstanding", pending_events.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // hand one item over; start stays up only for the accepting edge
    task automatic send_item(logic [2:0] cmd, logic [mstt_pkg::IV_W-1:0] iv,
                             logic [mstt_pkg::ID_W-1:0] tgt,
                             logic [mstt_pkg::TIME_W-1:0] now);
        i_command   <= cmd;
        i_interval  <= iv;
        i_target_id <= tgt;
        i_now_time  <= now;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_timer_cmd(cmd, iv, tgt, now);
        n_items++;
        start       <= 1'b0;
        // the block is busy in the cycle after accept anyway
        @(posedge i_clk);
        // mostly no extra gap, sometimes a short or long one
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        else if ($urandom_range(0, 29) == 0)
            repeat ($urandom_range(20, 120)) @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    // random create with mostly short intervals so timers actually expire
    function automatic logic [mstt_pkg::IV_W-1:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return mstt_pkg::IV_W'($urandom);
            2:       return {mstt_pkg::IV_W{1'b1}};
            default: return mstt_pkg::IV_W'($urandom_range(1, 40));
        endcase
    endfunction

    t_row rows[$];

    initial begin
        t_row r;
        logic [mstt_pkg::ID_W-1:0]   tgt;
        logic [mstt_pkg::TIME_W-1:0] now;
        int                          pick;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = '0;
        i_interval = '0;
        i_target_id = '0;
        i_now_time = '0;
        n_errors = 0;
        n_results = 0;
        n_fired = 0;
        n_items = 0;
        n_cycles = 0;
        foreach (tt_active[i]) tt_active[i] = 1'b0;
        tt_next_id = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: cmd, interval, target, now, id known, id
        rows = '{
            '{mstt_pkg::CMD_TICK,       0,  0, 0, 0, 0},
            '{mstt_pkg::CMD_ONESHOT,    0,  0, 0, 1, 0},   // zero interval
            '{mstt_pkg::CMD_ONESHOT,    1,  0, 0, 1, 1},   // first id
            '{mstt_pkg::CMD_PERIODIC,   10, 0, 0, 1, 2},
            '{mstt_pkg::CMD_PERIODIC,   {24{1'b1}}, 0, mstt_pkg::TIME_MAX, 1, 3}, // saturates
            '{mstt_pkg::CMD_TICK,       0,  0, 1,  0, 0},
            '{mstt_pkg::CMD_TICK,       0,  0, 45, 0, 0},  // late periodic
            '{mstt_pkg::CMD_CANCEL,     0,  0, 0,  0, 0},  // id zero ignored
            '{mstt_pkg::CMD_CANCEL,     0,  {31{1'b1}}, 0, 0, 0},   // unknown id
            '{mstt_pkg::CMD_CANCEL,     0,  2, 0,  0, 0},
            '{3'd5,                     7,  1, 1,  0, 0},  // unknown codes
            '{3'd6,                     0,  0, 0,  0, 0},
            '{3'd7, {24{1'b1}}, {31{1'b1}}, mstt_pkg::TIME_MAX, 0, 0},
            '{mstt_pkg::CMD_TICK,       0,  0, mstt_pkg::TIME_MAX, 0, 0},
            '{mstt_pkg::CMD_CANCEL_ALL, 0,  0, 0,  0, 0},
            '{mstt_pkg::CMD_TICK,       0,  0, mstt_pkg::TIME_MAX, 0, 0}
        };
        foreach (rows[k]) begin
            r = rows[k];
            send_item(r.cmd, r.iv, r.tgt, r.now);
            if (r.chk_id && pending_events.size() != 0 &&
                pending_events[$].id !== r.want_id) begin
                $display("%0t: table row %0d expected id %0d, model has %0d", $time, k,
                         r.want_id, pending_events[$].id);
                n_errors++;
            end
        end

        // full table: 65 creates, one refused, then all fire in one tick
        for (int i = 0; i < N_SLOTS + 1; i++)
            send_item(i[0] ? mstt_pkg::CMD_PERIODIC : mstt_pkg::CMD_ONESHOT, 5, 0, 100);
        send_item(mstt_pkg::CMD_TICK, 0, 0, 200);
        send_item(mstt_pkg::CMD_CANCEL_ALL, 0, 0, 0);
        drain_results();

        // random part: mostly create/tick over an advancing clock
        clock_ms = 1000;
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            tgt  = (tt_next_id > 1 && $urandom_range(0, 3) != 0)
                   ? mstt_pkg::ID_W'($urandom_range(1, tt_next_id - 1))
                   : mstt_pkg::ID_W'($urandom);
            if ($urandom_range(0, 49) == 0)
                now = {mstt_pkg::TIME_W{1'b1}} - mstt_pkg::TIME_W'($urandom_range(0, 50));
            else
                now = clock_ms;
            if (pick < 40)
                send_item($urandom_range(0, 1) ? mstt_pkg::CMD_PERIODIC
                                               : mstt_pkg::CMD_ONESHOT,
                          pick_interval(), mstt_pkg::ID_W'($urandom), now);
            else if (pick < 75) begin
                clock_ms += $urandom_range(0, 25);
                send_item(mstt_pkg::CMD_TICK, mstt_pkg::IV_W'($urandom),
                          mstt_pkg::ID_W'($urandom), clock_ms);
            end else if (pick < 92)
                send_item(mstt_pkg::CMD_CANCEL, mstt_pkg::IV_W'($urandom), tgt,
                          mstt_pkg::TIME_W'({$urandom, $urandom}));
            else if (pick < 96)
                send_item(mstt_pkg::CMD_CANCEL_ALL, mstt_pkg::IV_W'($urandom), tgt, now);
            else
                send_item(3'($urandom_range(5, 7)), mstt_pkg::IV_W'($urandom), tgt, now);
            // hold off until everything is out
            if (n == N_RANDOM / 2)
                drain_results();
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        $display("run: %0d items, %0d results, %0d timer fires", n_items, n_results,
                 n_fired);
        if (n_errors == 0 && pending_events.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
